// ----- rtl/core/sis_pkg.sv -----
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants for the sorted index set
// Field widths, command and status codes, and the cell command bundle.
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int VALUE_W          = 32;
  localparam int OP_W             = 3;
  localparam int POS_W            = 6;
  localparam int STATUS_W         = 3;
  localparam int COUNT_W          = 7;
  localparam int DEFAULT_CAPACITY = 64;

  localparam logic [OP_W-1:0] OP_ADD        = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_UNIQUE = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd2;
  localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_AT    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADPOS  = 3'd4;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_REMOVE
  } cell_act_t;

  typedef struct packed {
    cell_act_t          act;
    logic [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- rtl/core/sis_cmd_if.sv -----
// ----------------------------------------------------------------------------
// sis_cmd_if: command channel
// One beat carries an op, a value and a sorted position.
// ----------------------------------------------------------------------------
interface sis_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [sis_pkg::OP_W-1:0]      op;
  logic [sis_pkg::VALUE_W-1:0]   value;
  logic [sis_pkg::POS_W-1:0]     position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

// ----- rtl/core/sis_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sis_rsp_if: response channel
// One beat carries a status, a read value and the entry count.
// ----------------------------------------------------------------------------
interface sis_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sis_pkg::STATUS_W-1:0]  status;
  logic [sis_pkg::VALUE_W-1:0]   value_out;
  logic [sis_pkg::COUNT_W-1:0]   count;

  modport source (output valid, output status, output value_out, output count, input ready);
  modport sink   (input valid, input status, input value_out, input count, output ready);
endinterface

// ----- rtl/core/sorted_index_set_top.sv -----
// ----------------------------------------------------------------------------
// sorted_index_set_top: ascending sorted set of 32-bit index values
// Chain of CAPACITY cells with a small command sequencer.
// ----------------------------------------------------------------------------
// Each command passes through accept and execute: in the accept cycle every
// cell compares its entry with the incoming value and registers the result;
// in the execute cycle the sequencer ORs the match flags, picks the status
// and, on insert or remove, the cells past the position shift in one step.
// The next command is taken the cycle after execute once the response
// register is drained; no command is taken before the last one is done.
// The store needs no clearing pass: entries at or above the count are never read.
module sorted_index_set_top #(
  parameter int CAPACITY = sis_pkg::DEFAULT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  sis_cmd_if.sink   cmd,
  sis_rsp_if.source rsp
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int RD_N = (CAPACITY < (1 << sis_pkg::POS_W)) ? CAPACITY
                                                           : (1 << sis_pkg::POS_W);

  logic [sis_pkg::VALUE_W-1:0] entry_vec [CAPACITY];
  logic [CAPACITY-1:0]         le_vec;
  logic [CAPACITY-1:0]         eq_vec;
  logic [CAPACITY-1:0]         used_vec;
  logic                        cap_en;
  logic                        found;
  logic [sis_pkg::VALUE_W-1:0] rd_value;
  logic [CW-1:0]               count;
  sis_pkg::cell_cmd_t          cell_cmd;
  logic [sis_pkg::POS_W-1:0]   rd_pos;

  assign found  = |eq_vec;
  assign rd_pos = cmd.position;

  sis_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rsp      (rsp),
    .found    (found),
    .rd_value (rd_value),
    .cap_en   (cap_en),
    .cell_cmd (cell_cmd),
    .count    (count)
  );

  // read position is sampled with the entries at the accept edge
  logic [sis_pkg::VALUE_W-1:0] rd_sel;
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (rd_pos == sis_pkg::POS_W'(i)) begin
        rd_sel = rd_sel | entry_vec[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap_en) begin
      rd_value <= rd_sel;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                        left_le;
    logic [sis_pkg::VALUE_W-1:0] left_entry;
    logic [sis_pkg::VALUE_W-1:0] right_entry;

    assign used_vec[g] = CW'(g) < count;

    if (g == 0) begin : g_first
      assign left_le    = 1'b1;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_le    = le_vec[g-1];
      assign left_entry = entry_vec[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entry_vec[g+1];
    end

    sis_cell u_cell (
      .clk         (clk),
      .cap_en      (cap_en),
      .used        (used_vec[g]),
      .cmp_value   (cmd.value),
      .cmd         (cell_cmd),
      .left_le     (left_le),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry_vec[g]),
      .le          (le_vec[g]),
      .eq          (eq_vec[g])
    );
  end

endmodule

// ----- rtl/core/sis_cell.sv -----
// ----------------------------------------------------------------------------
// sis_cell: one slot of the sorted chain
// Holds one entry, registers its compare flags against the incoming value,
// and on insert takes the new value or the left entry, on remove the right entry.
// ----------------------------------------------------------------------------
module sis_cell (
  input  logic                        clk,
  input  logic                        cap_en,
  input  logic                        used,
  input  logic [sis_pkg::VALUE_W-1:0] cmp_value,
  input  sis_pkg::cell_cmd_t          cmd,
  input  logic                        left_le,
  input  logic [sis_pkg::VALUE_W-1:0] left_entry,
  input  logic [sis_pkg::VALUE_W-1:0] right_entry,
  output logic [sis_pkg::VALUE_W-1:0] entry,
  output logic                        le,
  output logic                        eq
);

  logic                        lt;
  logic [sis_pkg::VALUE_W-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    case (cmd.act)
      sis_pkg::ACT_INSERT: begin
        if (!le) begin
          entry_next = left_le ? cmd.value : left_entry;
        end
      end
      sis_pkg::ACT_REMOVE: begin
        if (!lt) begin
          entry_next = right_entry;
        end
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (cap_en) begin
      le <= used && (entry <= cmp_value);
      lt <= used && (entry < cmp_value);
      eq <= used && (entry == cmp_value);
    end
  end

endmodule

// ----- rtl/core/sis_ctrl.sv -----
// ----------------------------------------------------------------------------
// sis_ctrl: command sequencer for the sorted index set
// Latches a command beat, decides status and cell action in the execute
// cycle, keeps the entry count and drives the registered response.
// ----------------------------------------------------------------------------
module sis_ctrl #(
  parameter int CAPACITY = sis_pkg::DEFAULT_CAPACITY,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  sis_cmd_if.sink                     cmd,
  sis_rsp_if.source                   rsp,
  input  logic                        found,
  input  logic [sis_pkg::VALUE_W-1:0] rd_value,
  output logic                        cap_en,
  output sis_pkg::cell_cmd_t          cell_cmd,
  output logic [CW-1:0]               count
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                         state;
  logic [sis_pkg::OP_W-1:0]       op_q;
  logic [sis_pkg::VALUE_W-1:0]    value_q;
  logic [sis_pkg::POS_W-1:0]      pos_q;
  logic [CW-1:0]                  count_next;
  logic [sis_pkg::STATUS_W-1:0]   status_next;
  logic [sis_pkg::VALUE_W-1:0]    vout_next;
  logic                           full;

  assign cmd.ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign cap_en    = cmd.valid && cmd.ready;
  assign full      = (count == CW'(CAPACITY));

  always_comb begin
    count_next     = count;
    status_next    = sis_pkg::ST_DONE;
    vout_next      = '0;
    cell_cmd.act   = sis_pkg::ACT_HOLD;
    cell_cmd.value = value_q;
    if (state == S_EXEC) begin
      unique case (op_q)
        sis_pkg::OP_ADD: begin
          if (full) begin
            status_next = sis_pkg::ST_FULL;
          end else begin
            cell_cmd.act = sis_pkg::ACT_INSERT;
            count_next   = count + CW'(1);
          end
        end
        sis_pkg::OP_ADD_UNIQUE: begin
          if (found) begin
            status_next = sis_pkg::ST_PRESENT;
          end else if (full) begin
            status_next = sis_pkg::ST_FULL;
          end else begin
            cell_cmd.act = sis_pkg::ACT_INSERT;
            count_next   = count + CW'(1);
          end
        end
        sis_pkg::OP_REMOVE: begin
          if (found) begin
            cell_cmd.act = sis_pkg::ACT_REMOVE;
            count_next   = count - CW'(1);
          end else begin
            status_next = sis_pkg::ST_ABSENT;
          end
        end
        sis_pkg::OP_CONTAINS: begin
          if (!found) begin
            status_next = sis_pkg::ST_ABSENT;
          end
        end
        sis_pkg::OP_CLEAR: begin
          count_next = '0;
        end
        sis_pkg::OP_READ_AT: begin
          if (32'(pos_q) < 32'(count)) begin
            vout_next = rd_value;
          end else begin
            status_next = sis_pkg::ST_BADPOS;
          end
        end
        default: status_next = sis_pkg::ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (rsp.valid && rsp.ready) begin
            rsp.valid <= 1'b0;
          end
          if (cap_en) begin
            op_q    <= cmd.op;
            value_q <= cmd.value;
            pos_q   <= cmd.position;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          count         <= count_next;
          rsp.valid     <= 1'b1;
          rsp.status    <= status_next;
          rsp.value_out <= vout_next;
          rsp.count     <= sis_pkg::COUNT_W'(count_next);
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= CAPACITY)
    else $error("entry count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cap_en |=> (state == S_EXEC) && !rsp.valid)
    else $error("accepted beat did not enter execute with a free response slot");

  a_exec_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> rsp.valid && (state == S_IDLE))
    else $error("execute cycle did not produce a response");

  a_act_exec: assert property (@(posedge clk) disable iff (rst)
    (cell_cmd.act != sis_pkg::ACT_HOLD) |-> (state == S_EXEC))
    else $error("cell shift outside execute");

  a_shift_room: assert property (@(posedge clk) disable iff (rst)
    (cell_cmd.act == sis_pkg::ACT_INSERT) |-> !full)
    else $error("insert issued into a full chain");

endmodule
